// File: design/ntpcal_pkg.sv
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Shared constants, types and the month table for the NTP calendar block.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

    localparam logic [31:0] NtpUnixOffset = 32'd2208988800;
    localparam logic [31:0] Recip60K37    = 32'd2290649225;
    localparam logic [26:0] Recip60K32    = 27'd71582789;
    localparam logic [27:0] Recip24K32    = 28'd178956971;
    localparam logic [29:0] Recip7K32     = 30'd613566757;
    localparam logic [21:0] Recip1461K32  = 22'd2939757;
    localparam logic [14:0] DaysFrom1968  = 15'd731;
    localparam logic [10:0] DaysPerCycle  = 11'd1461;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
    } t_tod;

    typedef struct packed {
        logic valid;
        logic en;
    } t_ctl;

    // first day of year of month index 0..11
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] s;
        case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && idx >= 4'd2) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// File: design/ntpcal_date.sv
// ----------------------------------------------------------------------------
// ntpcal_date
// Day count since 1970 to year, month and day of month, two register stages.
// ----------------------------------------------------------------------------
module ntpcal_date (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntpcal_pkg::t_ctl    i_ctl,
    input  logic [14:0]         i_days,
    input  logic [4:0]          i_cycle,
    input  ntpcal_pkg::t_tod    i_tod,
    output logic                o_valid,
    output ntpcal_pkg::t_tod    o_tod,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day_of_month,
    output logic [7:0]          o_year_offset
);

    logic             r_v1, r_v2;
    logic [8:0]       r_doy, n_doy;
    logic             r_leap, n_leap;
    logic [7:0]       r_yoff1, n_yoff1;
    ntpcal_pkg::t_tod r_tod1, r_tod2;
    logic [3:0]       r_month, n_month;
    logic [4:0]       r_dom, n_dom;
    logic [7:0]       r_yoff2;

    logic [14:0] w_rem;
    logic [1:0]  w_yr;
    logic [8:0]  w_start;

    always_comb begin
        w_rem = i_days + ntpcal_pkg::DaysFrom1968
              - 15'(i_cycle) * 15'(ntpcal_pkg::DaysPerCycle);
        if (w_rem < 15'd366) begin
            w_yr  = 2'd0;
            n_doy = w_rem[8:0];
        end else if (w_rem < 15'd731) begin
            w_yr  = 2'd1;
            n_doy = 9'(w_rem - 15'd366);
        end else if (w_rem < 15'd1096) begin
            w_yr  = 2'd2;
            n_doy = 9'(w_rem - 15'd731);
        end else begin
            w_yr  = 2'd3;
            n_doy = 9'(w_rem - 15'd1096);
        end
        n_leap  = (w_yr == 2'd0);
        n_yoff1 = 8'({1'b0, i_cycle, 2'b00} + {4'd0, w_yr} - 8'd2);
    end

    always_comb begin
        n_month = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_doy >= ntpcal_pkg::month_start(r_leap, 4'(i))) begin
                n_month = 4'(i);
            end
        end
        w_start = ntpcal_pkg::month_start(r_leap, n_month);
        n_dom   = 5'(r_doy - w_start + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_doy   <= n_doy;
            r_leap  <= n_leap;
            r_yoff1 <= n_yoff1;
            r_tod1  <= i_tod;
            r_tod2  <= r_tod1;
            r_month <= n_month + 4'd1;
            r_dom   <= n_dom;
            r_yoff2 <= r_yoff1;
        end
    end

    assign o_valid        = r_v2;
    assign o_tod          = r_tod2;
    assign o_month        = r_month;
    assign o_day_of_month = r_dom;
    assign o_year_offset  = r_yoff2;

endmodule

// File: design/ntp_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_top
// NTP seconds since 1900 to UTC Gregorian date and time.
// ----------------------------------------------------------------------------
// Seven-stage pipeline: one item may enter every cycle while no result waits.
// Stage one takes off the Unix offset, the next four each do one reciprocal
// multiply (by 60, 60, 24, then 7 and 1461 in parallel), the last two find
// year and month. The whole pipeline stalls together while a result waits.
module ntp_seconds_to_calendar_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_ntp_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [7:0]  o_year_offset
);

    logic        w_en;
    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [30:0] r_t;
    logic [25:0] r_q60;
    logic [5:0]  r_t_lo;
    logic [5:0]  r_sec3, r_sec4, r_sec5;
    logic [19:0] r_h;
    logic [5:0]  r_q60_lo;
    logic [5:0]  r_min4, r_min5;
    logic [14:0] r_dd4, r_dd5;
    logic [4:0]  r_h_lo;
    logic [4:0]  r_hr5;
    logic [12:0] r_wq;
    logic [4:0]  r_cyc;

    logic [62:0] w_p60;
    logic [52:0] w_p3;
    logic [47:0] w_p24;
    logic [44:0] w_p7;
    logic [36:0] w_pc;
    logic [14:0] w_dd3;
    logic [2:0]  w_wrem;

    ntpcal_pkg::t_ctl w_ctl;
    ntpcal_pkg::t_tod w_tod, w_tod_out;
    logic             w_out_valid;

    assign w_en    = !w_out_valid || i_ready;
    assign o_ready = w_en;

    assign w_p60 = 63'(r_t) * 63'(ntpcal_pkg::Recip60K37);
    assign w_p3  = 53'(r_q60) * 53'(ntpcal_pkg::Recip60K32);
    assign w_p24 = 48'(r_h) * 48'(ntpcal_pkg::Recip24K32);
    assign w_p7  = 45'(r_dd4 + 15'd3) * 45'(ntpcal_pkg::Recip7K32);
    assign w_pc  = 37'(r_dd4 + ntpcal_pkg::DaysFrom1968) * 37'(ntpcal_pkg::Recip1461K32);
    assign w_dd3 = w_p24[46:32];
    assign w_wrem = 3'(r_dd5 + 15'd3 - 15'(r_wq * 13'd7));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t      <= (i_ntp_seconds > ntpcal_pkg::NtpUnixOffset)
                      ? 31'(i_ntp_seconds - ntpcal_pkg::NtpUnixOffset) : 31'd0;
            r_q60    <= w_p60[62:37];
            r_t_lo   <= r_t[5:0];
            r_sec3   <= 6'(r_t_lo - 6'(r_q60 * 26'd60));
            r_h      <= w_p3[51:32];
            r_q60_lo <= r_q60[5:0];
            r_sec4   <= r_sec3;
            r_min4   <= 6'(r_q60_lo - 6'(r_h * 20'd60));
            r_dd4    <= w_dd3;
            r_h_lo   <= r_h[4:0];
            r_sec5   <= r_sec4;
            r_min5   <= r_min4;
            r_hr5    <= 5'(r_h_lo - 5'(r_dd4 * 15'd24));
            r_dd5    <= r_dd4;
            r_wq     <= w_p7[44:32];
            r_cyc    <= w_pc[36:32];
        end
    end

    assign w_ctl.valid   = r_v5;
    assign w_ctl.en      = w_en;
    assign w_tod.second  = r_sec5;
    assign w_tod.minute  = r_min5;
    assign w_tod.hour    = r_hr5;
    assign w_tod.weekday = w_wrem + 3'd1;

    ntpcal_date u_date (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_days         (r_dd5),
        .i_cycle        (r_cyc),
        .i_tod          (w_tod),
        .o_valid        (w_out_valid),
        .o_tod          (w_tod_out),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_year_offset  (o_year_offset)
    );

    assign o_valid   = w_out_valid;
    assign o_second  = w_tod_out.second;
    assign o_minute  = w_tod_out.minute;
    assign o_hour    = w_tod_out.hour;
    assign o_weekday = w_tod_out.weekday;

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second < 6'd60) && (o_minute < 6'd60) && (o_hour < 5'd24))
        else $error("time field out of range");
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday >= 3'd1) && (o_weekday <= 3'd7))
        else $error("weekday out of range");
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12)
                 && (o_day_of_month >= 5'd1) && (o_year_offset <= 8'd66))
        else $error("date field out of range");

endmodule

// File: tb/ntpcal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpcal_checker
// Watches both channels of the NTP calendar block, works out the expected
// date and time of every accepted item and compares each result with it.
// ----------------------------------------------------------------------------
module ntpcal_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_ntp_seconds,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [5:0]  i_second,
    input  logic [5:0]  i_minute,
    input  logic [4:0]  i_hour,
    input  logic [2:0]  i_weekday,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [7:0]  i_year_offset,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [7:0] year_offset;
    } t_date;

    t_date dates_due[$];

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic t_date calendar_of(input logic [31:0] ntp);
        t_date d;
        int unsigned t, days, year, ylen, m, mlen;
        int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        t = (ntp > ntpcal_pkg::NtpUnixOffset) ? ntp - ntpcal_pkg::NtpUnixOffset : 0;
        d.second = t % 60;
        d.minute = (t / 60) % 60;
        d.hour = (t / 3600) % 24;
        days = t / 86400;
        d.weekday = (days + 3) % 7 + 1;
        year = 1970;
        forever begin
            ylen = leap_year(year) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            year++;
        end
        m = 0;
        while (m < 11) begin
            mlen = (m == 1 && leap_year(year)) ? 29 : mdays[m];
            if (days < mlen) break;
            days -= mlen;
            m++;
        end
        d.month = m + 1;
        d.day_of_month = days + 1;
        d.year_offset = year - 1970;
        return d;
    endfunction

    assign o_pending = dates_due.size();

    always @(posedge i_clk) begin
        t_date want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_in_ready) begin
                dates_due.push_back(calendar_of(i_ntp_seconds));
            end
            if (i_out_valid && i_ready) begin
                if (dates_due.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = dates_due.pop_front();
                    if (want != {i_second, i_minute, i_hour, i_weekday, i_month,
                                 i_day_of_month, i_year_offset}) begin
                        o_fail_count <= o_fail_count + 1;
                        if (want.second != i_second)
                            $error("second: expected %0d actual %0d", want.second, i_second);
                        if (want.minute != i_minute)
                            $error("minute: expected %0d actual %0d", want.minute, i_minute);
                        if (want.hour != i_hour)
                            $error("hour: expected %0d actual %0d", want.hour, i_hour);
                        if (want.weekday != i_weekday)
                            $error("weekday: expected %0d actual %0d", want.weekday,
                                   i_weekday);
                        if (want.month != i_month)
                            $error("month: expected %0d actual %0d", want.month, i_month);
                        if (want.day_of_month != i_day_of_month)
                            $error("day_of_month: expected %0d actual %0d",
                                   want.day_of_month, i_day_of_month);
                        if (want.year_offset != i_year_offset)
                            $error("year_offset: expected %0d actual %0d",
                                   want.year_offset, i_year_offset);
                    end
                end
            end
        end
    end

endmodule

// File: tb/tb_ntp_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntp_seconds_to_calendar_top
// Drives directed and random NTP seconds counts into the calendar block with
// random idling on both channels and a long output hold-off, then gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_ntp_seconds_to_calendar_top;

    localparam int NumRandom = 1830;
    localparam int CycleLimit = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_ntp_seconds = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [2:0]  o_weekday;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [7:0]  o_year_offset;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    always #6 i_clk = ~i_clk;

    ntp_seconds_to_calendar_top dut (.*);

    ntpcal_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_ntp_seconds,
        .i_out_valid(o_valid), .i_ready, .i_second(o_second), .i_minute(o_minute),
        .i_hour(o_hour), .i_weekday(o_weekday), .i_month(o_month),
        .i_day_of_month(o_day_of_month), .i_year_offset(o_year_offset),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("ntp_seconds_to_calendar_top: mismatch");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [31:0] v);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ntp_seconds <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_seconds();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 32'd2208988800);
            1: return 32'd2208988800 + $urandom_range(0, 200000);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 100000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$] = '{
            32'd0, 32'd1, 32'd2208988799, 32'd2208988800, 32'd2208988801,
            32'd2208988859, 32'd2208992399, 32'd2209075199, 32'd2209075200,
            32'd2211667199, 32'd2211667200, 32'd2272147200, 32'd2277244800,
            32'd2303596800, 32'd2335132799, 32'd3155587200, 32'd3155673600,
            32'd3160771200, 32'd3187123200, 32'd3786825600, 32'h8000_0000,
            32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_item(directed[k]);
        i_valid <= 1'b0;
        hold_off = 1'b1;
        for (int k = 0; k < 40; k++) send_item($urandom);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        for (int k = 0; k < NumRandom; k++) begin
            if (k == NumRandom - 200) calm = 1'b1;
            send_item(pick_seconds());
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("ntp_seconds_to_calendar_top: match");
        else
            $display("ntp_seconds_to_calendar_top: mismatch");
        $finish;
    end

endmodule

// File: ntp_seconds_to_calendar_top.f
design/ntpcal_pkg.sv
design/ntpcal_date.sv
design/ntp_seconds_to_calendar_top.sv
tb/ntpcal_checker.sv
tb/tb_ntp_seconds_to_calendar_top.sv
